[hdl/rps_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the preferred-series rounder.
// Depends on nothing; every other file in hdl/ imports it.
package rps_pkg;

  localparam int OUT_BITS     = 38;
  localparam int FACTOR_BITS  = 7;
  localparam int NMID         = 19;
  localparam int MID_IDX_BITS = 5;

  typedef logic [1:0]              mode_t;
  typedef logic [FACTOR_BITS-1:0]  factor_t;
  typedef logic [NMID-1:0]         mid_vec_t;
  typedef logic [MID_IDX_BITS-1:0] mid_idx_t;
  typedef logic [7:0]              mid_sum_t;

  localparam mode_t SERIES_125 = 2'd0;
  localparam mode_t SERIES_14  = 2'd1;
  localparam mode_t SERIES_26  = 2'd2;

  localparam factor_t FACTOR_MIN = 7'd10;
  localparam factor_t FACTOR_MAX = 7'd100;

  // Sum of two neighboring factors (in tenths) for every midpoint used by any series.
  // Comparing 20*|value| against sum*decade puts the item on one side of a midpoint.
  localparam mid_sum_t MID_SUM [NMID] = '{
    8'd22, 8'd25, 8'd27, 8'd30, 8'd32, 8'd35, 8'd37, 8'd45, 8'd50, 8'd55,
    8'd70, 8'd80, 8'd90, 8'd110, 8'd120, 8'd130, 8'd150, 8'd170, 8'd180
  };

  // Factors of each series in tenths, ascending, and the midpoint between
  // factor j and factor j+1 as an index into MID_SUM.
  localparam factor_t F125 [4] = '{7'd10, 7'd20, 7'd50, 7'd100};
  localparam mid_idx_t M125 [3] = '{5'd3, 5'd10, 5'd16};

  localparam factor_t F14 [7] = '{7'd10, 7'd15, 7'd20, 7'd30, 7'd50, 7'd70, 7'd100};
  localparam mid_idx_t M14 [6] = '{5'd1, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17};

  localparam factor_t F26 [13] = '{
    7'd10, 7'd12, 7'd15, 7'd17, 7'd20, 7'd25, 7'd30, 7'd40, 7'd50, 7'd60,
    7'd70, 7'd80, 7'd100
  };
  localparam mid_idx_t M26 [12] = '{
    5'd0, 5'd2, 5'd4, 5'd6, 5'd7, 5'd9, 5'd10, 5'd12, 5'd13, 5'd15, 5'd16, 5'd18
  };

  function automatic logic [63:0] pow10(input int d);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < d; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

  // Highest decade that a magnitude of a bits-wide two's complement value reaches.
  function automatic int max_decade(input int bits);
    int          d;
    logic [63:0] p;
    logic [63:0] lim;
    lim = 64'd1 << (bits - 1);
    p   = 64'd10;
    d   = 0;
    while (p <= lim) begin
      d = d + 1;
      p = p * 64'd10;
    end
    return d;
  endfunction

  // Thresholds are monotone, so the last midpoint passed names the factor.
  function automatic factor_t pick_factor(input mode_t mode, input mid_vec_t up);
    factor_t f;
    f = FACTOR_MIN;
    unique case (mode)
      SERIES_14: begin
        for (int j = 0; j < 6; j++) begin
          if (up[M14[j]]) f = F14[j+1];
        end
      end
      SERIES_26: begin
        for (int j = 0; j < 12; j++) begin
          if (up[M26[j]]) f = F26[j+1];
        end
      end
      default: begin
        for (int j = 0; j < 3; j++) begin
          if (up[M125[j]]) f = F125[j+1];
        end
      end
    endcase
    return f;
  endfunction

endpackage

[hdl/round_to_preferred_series_core.sv]
`timescale 1ns / 1ps
// Preferred-series rounder, top level: mode register and the six-stage pipeline.
// Depends on rps_pkg, rps_decade, rps_select and rps_scale.
//
// Usage:
//   Input channel in_valid/in_ready carries a signed value; output channel
//   out_valid/out_ready carries rounded_tenths, the nearest member of the
//   selected series (1-2-5, 14-step or 26-step) times ten. Zero stays zero.
//   cfg_wr_en/cfg_wr_data write series_mode (code 3 acts as 1-2-5); write it
//   only while no transaction is in flight.
//   Six register stages; the edge that accepts an input loads the first,
//   and the result is offered from the last. Throughput: one transaction
//   per cycle while out_ready stays high, set by the fully pipelined
//   datapath (decade compare, midpoint compare, one factor-times-decade
//   multiply).
//   Every stage advances on its own when the stage after it is empty or
//   moving, so bubbles close up while the receiver stalls; in_ready drops
//   only once all six stages hold data. Nothing is lost or repeated.
//   Reset (synchronous, active high) empties the pipeline and sets the
//   1-2-5 series.
module round_to_preferred_series_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  rps_pkg::mode_t                      cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [VALUE_BITS-1:0]        value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rps_pkg::OUT_BITS-1:0] rounded_tenths
);
  import rps_pkg::*;

  localparam int CHK_BITS = VALUE_BITS + 4;

  mode_t                 series_mode;
  logic                  dec_valid;
  logic                  dec_ready;
  logic                  dec_neg;
  logic                  dec_zero;
  logic [VALUE_BITS-1:0] dec_mag;
  logic [VALUE_BITS-1:0] dec_p;
  logic                  sel_valid;
  logic                  sel_ready;
  logic                  sel_neg;
  logic                  sel_zero;
  logic [VALUE_BITS-1:0] sel_p;
  factor_t               sel_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_mode <= SERIES_125;
    end else if (cfg_wr_en) begin
      series_mode <= cfg_wr_data;
    end
  end

  rps_decade #(.VALUE_BITS(VALUE_BITS)) u_decade (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_neg   (dec_neg),
    .dec_zero  (dec_zero),
    .dec_mag   (dec_mag),
    .dec_p     (dec_p)
  );

  rps_select #(.VALUE_BITS(VALUE_BITS)) u_select (
    .clk         (clk),
    .rst         (rst),
    .series_mode (series_mode),
    .in_valid    (dec_valid),
    .in_ready    (dec_ready),
    .in_neg      (dec_neg),
    .in_zero     (dec_zero),
    .in_mag      (dec_mag),
    .in_p        (dec_p),
    .sel_valid   (sel_valid),
    .sel_ready   (sel_ready),
    .sel_neg     (sel_neg),
    .sel_zero    (sel_zero),
    .sel_p       (sel_p),
    .sel_factor  (sel_factor)
  );

  rps_scale #(.VALUE_BITS(VALUE_BITS)) u_scale (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (sel_valid),
    .in_ready       (sel_ready),
    .in_neg         (sel_neg),
    .in_zero        (sel_zero),
    .in_p           (sel_p),
    .in_factor      (sel_factor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rounded_tenths (rounded_tenths)
  );

  // The decade is exact: p <= |value| < 10*p.
  a_decade_exact: assert property (@(posedge clk) disable iff (rst)
    dec_valid && (dec_mag != '0) |->
      (dec_p <= dec_mag) &&
      (CHK_BITS'(dec_mag) < ((CHK_BITS'(dec_p) << 3) + (CHK_BITS'(dec_p) << 1))))
    else $error("decade stage produced a power of ten outside the magnitude's decade");

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    sel_valid |-> (sel_factor >= FACTOR_MIN) && (sel_factor <= FACTOR_MAX))
    else $error("selected factor outside the series range");

  // Back-pressure reaches the input only when the output register is full.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while the output stage is empty");

endmodule

[hdl/rps_decade.sv]
`timescale 1ns / 1ps
// Front two pipeline stages: sign and magnitude, then the decimal decade of the magnitude.
// Depends on rps_pkg (pow10, max_decade).
module rps_decade #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         dec_valid,
  input  logic                         dec_ready,
  output logic                         dec_neg,
  output logic                         dec_zero,
  output logic [VALUE_BITS-1:0]        dec_mag,
  output logic [VALUE_BITS-1:0]        dec_p
);
  import rps_pkg::*;

  localparam int MAX_DEC = max_decade(VALUE_BITS);

  logic                  s1_valid;
  logic                  a_valid;
  logic                  a_ready;
  logic                  a_neg;
  logic                  a_zero;
  logic [VALUE_BITS-1:0] a_mag;
  logic [VALUE_BITS-1:0] a_mag_next;
  logic [VALUE_BITS-1:0] p_next;

  assign a_ready  = !a_valid || dec_ready;
  assign in_ready = !s1_valid || a_ready;

  // The most negative value maps onto 2^(VALUE_BITS-1), which the unsigned field holds.
  assign a_mag_next = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  always_comb begin
    p_next = VALUE_BITS'(1);
    for (int d = 1; d <= MAX_DEC; d++) begin
      if (a_mag >= VALUE_BITS'(pow10(d))) p_next = VALUE_BITS'(pow10(d));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      a_valid  <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (a_ready)  a_valid  <= s1_valid;
    end
  end

  // Stage names run input side first: s1_* registers feed s2_* which feed the output.
  logic                  s1_neg;
  logic                  s1_zero;
  logic [VALUE_BITS-1:0] s1_mag;

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_neg  <= value[VALUE_BITS-1];
      s1_zero <= (value == '0);
      s1_mag  <= a_mag_next;
    end
  end

  assign a_neg  = s1_neg;
  assign a_zero = s1_zero;
  assign a_mag  = s1_mag;

  logic                  s2_neg;
  logic                  s2_zero;
  logic [VALUE_BITS-1:0] s2_mag;
  logic [VALUE_BITS-1:0] s2_p;

  always_ff @(posedge clk) begin
    if (a_ready && s1_valid) begin
      s2_neg  <= a_neg;
      s2_zero <= a_zero;
      s2_mag  <= a_mag;
      s2_p    <= p_next;
    end
  end

  // Output of this module is the second stage.
  assign dec_valid = a_valid;
  assign dec_neg   = s2_neg;
  assign dec_zero  = s2_zero;
  assign dec_mag   = s2_mag;
  assign dec_p     = s2_p;

endmodule

[hdl/rps_select.sv]
`timescale 1ns / 1ps
// Middle two pipeline stages: midpoint thresholds for the decade, then the factor choice.
// Depends on rps_pkg (MID_SUM, pick_factor, mode and factor types).
module rps_select #(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rps_pkg::mode_t          series_mode,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_neg,
  input  logic                    in_zero,
  input  logic [VALUE_BITS-1:0]   in_mag,
  input  logic [VALUE_BITS-1:0]   in_p,
  output logic                    sel_valid,
  input  logic                    sel_ready,
  output logic                    sel_neg,
  output logic                    sel_zero,
  output logic [VALUE_BITS-1:0]   sel_p,
  output rps_pkg::factor_t        sel_factor
);
  import rps_pkg::*;

  localparam int CMP_BITS = VALUE_BITS + 8;

  logic                  c_valid;
  logic                  c_ready;
  logic                  d_ready;
  logic                  c_neg;
  logic                  c_zero;
  logic [VALUE_BITS-1:0] c_p;
  logic [CMP_BITS-1:0]   c_t20;
  logic [CMP_BITS-1:0]   c_thr [NMID];
  logic [CMP_BITS-1:0]   thr_next [NMID];
  logic [CMP_BITS-1:0]   t20_next;
  mid_vec_t              up;
  factor_t               factor_next;

  assign d_ready  = !sel_valid || sel_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  always_comb begin
    for (int k = 0; k < NMID; k++) begin
      thr_next[k] = CMP_BITS'(in_p) * CMP_BITS'(MID_SUM[k]);
    end
  end

  assign t20_next = (CMP_BITS'(in_mag) << 4) + (CMP_BITS'(in_mag) << 2);

  // A tie goes to the lower candidate: the smaller factor for a positive value,
  // the larger one for a negative value.
  always_comb begin
    for (int k = 0; k < NMID; k++) begin
      up[k] = c_neg ? (c_t20 >= c_thr[k]) : (c_t20 > c_thr[k]);
    end
  end

  assign factor_next = pick_factor(series_mode, up);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      sel_valid <= 1'b0;
    end else begin
      if (c_ready) c_valid   <= in_valid;
      if (d_ready) sel_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_neg  <= in_neg;
      c_zero <= in_zero;
      c_p    <= in_p;
      c_t20  <= t20_next;
      c_thr  <= thr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      sel_neg    <= c_neg;
      sel_zero   <= c_zero;
      sel_p      <= c_p;
      sel_factor <= factor_next;
    end
  end

endmodule

[hdl/rps_scale.sv]
`timescale 1ns / 1ps
// Last two pipeline stages: factor times decade, then sign, zero and saturation.
// Depends on rps_pkg (OUT_BITS, factor type).
module rps_scale #(
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_neg,
  input  logic                              in_zero,
  input  logic [VALUE_BITS-1:0]             in_p,
  input  rps_pkg::factor_t                  in_factor,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rps_pkg::OUT_BITS-1:0] rounded_tenths
);
  import rps_pkg::*;

  localparam int PROD_BITS = VALUE_BITS + FACTOR_BITS;
  localparam int EXT_BITS  = ((PROD_BITS > OUT_BITS) ? PROD_BITS : OUT_BITS) + 1;
  localparam logic [EXT_BITS-1:0] POS_LIM = EXT_BITS'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam logic [EXT_BITS-1:0] NEG_LIM = EXT_BITS'(64'd1 << (OUT_BITS - 1));
  localparam logic [OUT_BITS-1:0] POS_SAT = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] NEG_SAT = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic                  e_valid;
  logic                  e_ready;
  logic                  f_ready;
  logic                  e_neg;
  logic                  e_zero;
  logic [PROD_BITS-1:0]  e_prod;
  logic [PROD_BITS-1:0]  prod_next;
  logic [EXT_BITS-1:0]   prod_ext;
  logic [EXT_BITS-1:0]   signed_ext;
  logic [OUT_BITS-1:0]   result_next;

  assign f_ready  = !out_valid || out_ready;
  assign e_ready  = !e_valid || f_ready;
  assign in_ready = e_ready;

  assign prod_next = PROD_BITS'(in_p) * PROD_BITS'(in_factor);

  assign prod_ext   = EXT_BITS'(e_prod);
  assign signed_ext = e_neg ? (~prod_ext + 1'b1) : prod_ext;

  always_comb begin
    priority if (e_zero) begin
      result_next = '0;
    end else if (e_neg && (prod_ext > NEG_LIM)) begin
      result_next = NEG_SAT;
    end else if (!e_neg && (prod_ext > POS_LIM)) begin
      result_next = POS_SAT;
    end else begin
      result_next = signed_ext[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (e_ready) e_valid   <= in_valid;
      if (f_ready) out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && in_valid) begin
      e_neg  <= in_neg;
      e_zero <= in_zero;
      e_prod <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && e_valid) begin
      rounded_tenths <= result_next;
    end
  end

endmodule

[bench/round_to_preferred_series_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for round_to_preferred_series_core: queue-fed driver, monitor,
// and a nearest-series predictor in tenths. Depends on rps_pkg and the hdl/ sources.
module round_to_preferred_series_core_tb;
  import rps_pkg::*;

  localparam int     VBITS       = 32;
  localparam int     PHASE_ITEMS = 180;
  localparam int     HOLD_CYCLES = 300;
  localparam int     CYCLE_LIMIT = 200000;
  localparam longint OUT_MAX     = (longint'(1) <<< (OUT_BITS - 1)) - 1;
  localparam longint OUT_MIN     = -OUT_MAX - 1;

  // code 3 is not a named series; the block treats it as 1-2-5
  localparam mode_t SERIES_UNUSED = 2'd3;

  localparam int FAC_125 [4]  = '{10, 20, 50, 100};
  localparam int FAC_14  [7]  = '{10, 15, 20, 30, 50, 70, 100};
  localparam int FAC_26  [13] = '{10, 12, 15, 17, 20, 25, 30, 40, 50, 60, 70, 80, 100};

  localparam mode_t PHASE_MODE [8] = '{SERIES_125, SERIES_14, SERIES_26, SERIES_UNUSED,
                                       SERIES_26, SERIES_14, SERIES_125, SERIES_26};
  localparam int SEND_IDLE  [4] = '{0, 69, 0, 23};
  localparam int RECV_STALL [4] = '{0, 0, 69, 23};

  localparam logic signed [VBITS-1:0] EDGE_VALUES [23] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd2, 32'sd3, 32'sd7, -32'sd7, 32'sd9, 32'sd10, 32'sd11,
    32'sd15, -32'sd15, 32'sd35, 32'sd75, -32'sd75, 32'sd99, 32'sd100,
    32'sd999999999, 32'sd1000000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
    32'sh55555555
  };

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  mode_t                      cfg_wr_data = SERIES_125;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [VBITS-1:0]    value     = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_BITS-1:0] rounded_tenths;

  logic signed [VBITS-1:0]    pending_values  [$];
  logic signed [OUT_BITS-1:0] expected_tenths [$];

  mode_t cur_mode       = SERIES_125;
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  int    hold_requests  = 0;
  int    hold_served    = 0;
  int    hold_left      = 0;
  int    err_count      = 0;
  int    cycle_count    = 0;

  round_to_preferred_series_core #(.VALUE_BITS(VBITS)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rounded_tenths (rounded_tenths)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint ten_pow(input int d);
    longint r;
    r = 1;
    for (int i = 0; i < d; i++) r = r * 10;
    return r;
  endfunction

  function automatic int series_len(input mode_t m);
    case (m)
      SERIES_14: return 7;
      SERIES_26: return 13;
      default:   return 4;
    endcase
  endfunction

  function automatic longint series_factor(input mode_t m, input int i);
    case (m)
      SERIES_14: return FAC_14[i];
      SERIES_26: return FAC_26[i];
      default:   return FAC_125[i];
    endcase
  endfunction

  function automatic logic signed [OUT_BITS-1:0] nearest_series_tenths(
    input logic signed [VBITS-1:0] v, input mode_t m);
    longint sv, mag, decade, target, cand, err, best, best_err;
    int     n;
    sv = longint'(v);
    if (sv == 0) return '0;
    mag    = (sv < 0) ? -sv : sv;
    decade = 1;
    while (decade <= mag / 10) decade = decade * 10;
    target   = sv * 10;
    n        = series_len(m);
    best     = 0;
    best_err = -1;
    // walk candidates from most negative upward; strict compare keeps the lower on a tie
    for (int k = 0; k < 2 * n; k++) begin
      cand = (k < n) ? -series_factor(m, n - 1 - k) * decade : series_factor(m, k - n) * decade;
      err  = (cand > target) ? cand - target : target - cand;
      if (best_err < 0 || err < best_err) begin
        best     = cand;
        best_err = err;
      end
    end
    if (best > OUT_MAX) best = OUT_MAX;
    if (best < OUT_MIN) best = OUT_MIN;
    return best[OUT_BITS-1:0];
  endfunction

  function automatic logic signed [VBITS-1:0] random_value(input mode_t m);
    int     kind, d, j;
    longint lo, hi, mag;
    kind = $urandom_range(99);
    if (kind < 15) return $urandom;
    if (kind < 60) begin
      // uniform within a random decade
      d   = $urandom_range(9);
      lo  = ten_pow(d);
      hi  = (d == 9) ? 64'sh80000000 : ten_pow(d + 1) - 1;
      mag = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
    end else if (kind < 85) begin
      // on or next to the midpoint between two neighboring factors
      j   = $urandom_range(series_len(m) - 2);
      d   = $urandom_range(8);
      mag = (series_factor(m, j) + series_factor(m, j + 1)) * ten_pow(d) / 20;
      mag = mag + longint'($urandom_range(2)) - 1;
    end else begin
      // around a decade boundary
      d   = $urandom_range(9);
      mag = ten_pow(d) + longint'($urandom_range(2)) - 1;
    end
    if ($urandom_range(1) == 1) begin
      mag = -mag;
    end else if (mag > 64'sh7FFFFFFF) begin
      mag = 64'sh7FFFFFFF;
    end
    return mag[VBITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic signed [OUT_BITS-1:0] got,
                                 input logic signed [OUT_BITS-1:0] want);
    $display("[%0t] mismatch: %s: rounded_tenths got %0d expected %0d", $realtime, what, got,
             want);
    err_count++;
  endtask

  // driver: present the next value and predict on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_tenths.push_back(nearest_series_tenths(value, cur_mode));
      end
      if (!in_valid || in_ready) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          value    <= pending_values.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tenths.size() == 0) begin
          report_mismatch("unexpected result", rounded_tenths, 'x);
        end else if (rounded_tenths !== expected_tenths[0]) begin
          report_mismatch("wrong value", rounded_tenths, expected_tenths.pop_front());
        end else begin
          void'(expected_tenths.pop_front());
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain_all();
    while (pending_values.size() != 0 || in_valid || expected_tenths.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    cur_mode = m;
  endtask

  initial begin
    int p;
    int k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // edge values against the reset series
    for (k = 0; k < 23; k++) pending_values.push_back(EDGE_VALUES[k]);
    drain_all();

    for (p = 0; p < 8; p++) begin
      write_mode(PHASE_MODE[p]);
      send_idle_pct  = SEND_IDLE[p % 4];
      recv_stall_pct = RECV_STALL[p % 4];
      for (k = 0; k < PHASE_ITEMS; k++) pending_values.push_back(random_value(cur_mode));
      // back up the pipeline while the sender keeps offering
      if (p == 4) hold_requests++;
      drain_all();
    end

    if (expected_tenths.size() != 0) begin
      report_mismatch("result never arrived", 'x, expected_tenths[0]);
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rps_pkg.sv
hdl/rps_decade.sv
hdl/rps_select.sv
hdl/rps_scale.sv
hdl/round_to_preferred_series_core.sv
bench/round_to_preferred_series_core_tb.sv
